// ===== rtl/core/sdx_pkg.sv =====
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared types, constants and letter classing for the Soundex word encoder.
// ----------------------------------------------------------------------------
package sdx_pkg;

  // Code length: leading letter plus digits.
  localparam int CodeLength = 4;
  localparam int NumDigits  = 3;
  localparam int DigitLimitInt =
    (CodeLength - 1 > NumDigits) ? NumDigits :
    ((CodeLength - 1 < 0) ? 0 : CodeLength - 1);
  localparam logic [1:0] DIGIT_LIMIT = 2'(DigitLimitInt);

  localparam int CharW  = 8;
  localparam int DigitW = 3;
  localparam int InDataW  = 8;   // character, already whole bytes
  localparam int OutDataW = 24;  // 8 + 3*3 = 17 bits, padded to 3 bytes

  typedef logic [DigitW-1:0] digit_t;

  // One input item as it travels from the input stage to the encoder.
  typedef struct packed {
    logic [CharW-1:0] character;
    logic             word_end;
  } sdx_item_t;

  // One finished code.
  typedef struct packed {
    digit_t           digit_three;
    digit_t           digit_two;
    digit_t           digit_one;
    logic [CharW-1:0] first_letter;
  } sdx_code_t;

  // Consonant class; 0 for vowels, h w y, uppercase and all other bytes.
  function automatic digit_t class_code(input logic [CharW-1:0] c);
    digit_t code;
    unique case (c)
      "b", "p", "v", "f":                     code = 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": code = 3'd2;
      "d", "t":                               code = 3'd3;
      "l":                                    code = 3'd4;
      "m", "n":                               code = 3'd5;
      "r":                                    code = 3'd6;
      default:                                code = 3'd0;
    endcase
    return code;
  endfunction

  function automatic logic is_vowel(input logic [CharW-1:0] c);
    return (c == "a") || (c == "e") || (c == "i") || (c == "o") || (c == "u");
  endfunction

  // A-Z folded to lowercase; everything else unchanged.
  function automatic logic [CharW-1:0] fold_lower(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c | 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sdx_input_stage.sv =====
// ----------------------------------------------------------------------------
// sdx_input_stage
// Input register: holds one accepted character until the encoder takes it.
// ----------------------------------------------------------------------------
module sdx_input_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sdx_pkg::sdx_item_t in_item_i,
  output logic               item_valid_o,
  input  logic               item_take_i,
  output sdx_pkg::sdx_item_t item_o
);
  import sdx_pkg::*;

  logic      valid_q, valid_d;
  sdx_item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== rtl/core/sdx_encode.sv =====
// ----------------------------------------------------------------------------
// sdx_encode
// Word state and the per-character Soundex update; forms the code on word end.
// ----------------------------------------------------------------------------
module sdx_encode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  sdx_pkg::sdx_item_t item_i,
  output sdx_pkg::sdx_code_t code_o
);
  import sdx_pkg::*;

  logic             started_q, started_d;
  logic [CharW-1:0] first_q, first_d;
  logic [1:0]       taken_q, taken_d;
  digit_t           digits_q [NumDigits];
  digit_t           digits_d [NumDigits];
  digit_t           prev_q, prev_d;
  logic             vowel_q, vowel_d;

  digit_t           code;

  assign code = class_code(item_i.character);

  always_comb begin
    started_d = started_q;
    first_d   = first_q;
    taken_d   = taken_q;
    prev_d    = prev_q;
    vowel_d   = vowel_q;
    for (int i = 0; i < NumDigits; i++) begin
      digits_d[i] = digits_q[i];
    end

    if (!started_q) begin
      started_d = 1'b1;
      first_d   = item_i.character;
      taken_d   = 2'd0;
      prev_d    = class_code(fold_lower(item_i.character));
      vowel_d   = 1'b0;
      for (int i = 0; i < NumDigits; i++) begin
        digits_d[i] = '0;
      end
    end else if (taken_q < DIGIT_LIMIT) begin
      if (code != '0) begin
        // a vowel in between lets a repeated class through
        if (code != prev_q || vowel_q) begin
          for (int i = 0; i < NumDigits; i++) begin
            if (taken_q == 2'(i)) begin
              digits_d[i] = code;
            end
          end
          taken_d = taken_q + 2'd1;
        end
        prev_d  = code;
        vowel_d = 1'b0;
      end else if (is_vowel(item_i.character)) begin
        vowel_d = 1'b1;
      end
    end
  end

  // code formed from the state after this character
  always_comb begin
    code_o.first_letter = first_d;
    code_o.digit_one    = digits_d[0];
    code_o.digit_two    = digits_d[1];
    code_o.digit_three  = digits_d[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      first_q   <= '0;
      taken_q   <= '0;
      prev_q    <= '0;
      vowel_q   <= 1'b0;
      for (int i = 0; i < NumDigits; i++) begin
        digits_q[i] <= '0;
      end
    end else if (step_i) begin
      if (item_i.word_end) begin
        started_q <= 1'b0;
        first_q   <= '0;
        taken_q   <= '0;
        prev_q    <= '0;
        vowel_q   <= 1'b0;
        for (int i = 0; i < NumDigits; i++) begin
          digits_q[i] <= '0;
        end
      end else begin
        started_q <= started_d;
        first_q   <= first_d;
        taken_q   <= taken_d;
        prev_q    <= prev_d;
        vowel_q   <= vowel_d;
        for (int i = 0; i < NumDigits; i++) begin
          digits_q[i] <= digits_d[i];
        end
      end
    end
  end

endmodule

// ===== rtl/core/sdx_output_stage.sv =====
// ----------------------------------------------------------------------------
// sdx_output_stage
// Result register: holds one finished code until the sink takes it.
// ----------------------------------------------------------------------------
module sdx_output_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  sdx_pkg::sdx_code_t code_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sdx_pkg::sdx_code_t code_o
);
  import sdx_pkg::*;

  logic      valid_q, valid_d;
  sdx_code_t code_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (free_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      code_q <= code_i;
    end
  end

  assign out_valid_o = valid_q;
  assign code_o      = code_q;

endmodule

// ===== rtl/core/soundex_word_encoder_top.sv =====
// ----------------------------------------------------------------------------
// soundex_word_encoder_top
// Streams a word one character per item and emits its four-place Soundex code.
// ----------------------------------------------------------------------------
// Channel   Dir  Bus group   Content
// s_axis    in   tdata/tlast character, tlast marks the last character
// m_axis    out  tdata       first letter and three class digits
//
// One character per cycle unless a last character waits on a full result
// register. The input register takes the last character; the result register
// then loads the class lookup and state update and raises m_axis_tvalid_o.
// Reset clears the word state and both valid flags; no clearing pass.
// A stalled sink holds only the last-character item; other characters
// keep flowing while a finished code waits.
// ----------------------------------------------------------------------------
module soundex_word_encoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [sdx_pkg::InDataW-1:0]    s_axis_tdata_i,   // [7:0] character
  input  logic                           s_axis_tlast_i,   // word_end
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [7:0] first_letter, [10:8] digit_one, [13:11] digit_two,
  // [16:14] digit_three, [23:17] zero
  output logic [sdx_pkg::OutDataW-1:0]   m_axis_tdata_o
);
  import sdx_pkg::*;

  sdx_item_t in_item, item;
  sdx_code_t code_next, code_out;
  logic      item_valid, item_take, out_free;

  assign in_item.character = s_axis_tdata_i[CharW-1:0];
  assign in_item.word_end  = s_axis_tlast_i;

  sdx_input_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  // a last character waits only for room in the result register
  assign item_take = item_valid && (!item.word_end || out_free);

  sdx_encode u_enc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (item_take),
    .item_i (item),
    .code_o (code_next)
  );

  sdx_output_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (item_take && item.word_end),
    .code_i      (code_next),
    .free_o      (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .code_o      (code_out)
  );

  assign m_axis_tdata_o = {{(OutDataW - CharW - 3*DigitW){1'b0}},
                           code_out.digit_three, code_out.digit_two,
                           code_out.digit_one, code_out.first_letter};

endmodule

// ===== sim/soundex_word_encoder_top_test.sv =====
// ----------------------------------------------------------------------------
// soundex_word_encoder_top_test
// Self-checking bench for the streamed Soundex word encoder. Words go in one
// character per item; a checker class rebuilds each code from the accepted
// characters and compares it field by field against the output stream. Both
// stream sides stall at random, with quiet stretches and full drains.
// ----------------------------------------------------------------------------

// Rebuilds Soundex codes from accepted characters and checks emitted codes.
class soundex_code_checker;
  sdx_pkg::sdx_code_t pending_codes[$];
  int                 error_count;
  int                 codes_checked;

  // word state
  bit                 started;
  logic [7:0]         lead_char;
  logic [1:0]         taken;
  sdx_pkg::digit_t    kept_digits[3];
  sdx_pkg::digit_t    last_class;
  bit                 vowel_seen;

  function new();
    error_count   = 0;
    codes_checked = 0;
    clear_word();
  endfunction

  function void clear_word();
    started        = 1'b0;
    lead_char      = '0;
    taken          = '0;
    kept_digits[0] = '0;
    kept_digits[1] = '0;
    kept_digits[2] = '0;
    last_class     = '0;
    vowel_seen     = 1'b0;
  endfunction

  function sdx_pkg::digit_t letter_class(logic [7:0] ch);
    case (ch)
      "b", "p", "v", "f":                     return 3'd1;
      "c", "g", "j", "k", "q", "s", "x", "z": return 3'd2;
      "d", "t":                               return 3'd3;
      "l":                                    return 3'd4;
      "m", "n":                               return 3'd5;
      "r":                                    return 3'd6;
      default:                                return 3'd0;
    endcase
  endfunction

  function void take_character(logic [7:0] ch, logic last);
    logic [7:0]         folded;
    sdx_pkg::digit_t    cls;
    sdx_pkg::sdx_code_t code;
    if (!started) begin
      // only the lead letter is case-folded, and only to seed the class
      folded = ch;
      if (ch >= "A" && ch <= "Z") begin
        folded = ch + 8'd32;
      end
      clear_word();
      started    = 1'b1;
      lead_char  = ch;
      last_class = letter_class(folded);
    end else if (taken < sdx_pkg::DIGIT_LIMIT) begin
      cls = letter_class(ch);
      if (cls != 3'd0) begin
        if (cls != last_class || vowel_seen) begin
          kept_digits[taken] = cls;
          taken = taken + 2'd1;
        end
        last_class = cls;
        vowel_seen = 1'b0;
      end else if (ch inside {"a", "e", "i", "o", "u"}) begin
        vowel_seen = 1'b1;
      end
    end
    if (last) begin
      code.first_letter = lead_char;
      code.digit_one    = kept_digits[0];
      code.digit_two    = kept_digits[1];
      code.digit_three  = kept_digits[2];
      pending_codes = {pending_codes, code};
      clear_word();
    end
  endfunction

  function void check_code(logic [sdx_pkg::OutDataW-1:0] data);
    sdx_pkg::sdx_code_t got;
    sdx_pkg::sdx_code_t want;
    got = data[16:0];
    if (pending_codes.size() == 0) begin
      error_count++;
      $error("code %h emitted with no word pending", data);
      return;
    end
    want = pending_codes.pop_front();
    codes_checked++;
    if (got.first_letter !== want.first_letter) begin
      error_count++;
      $error("first_letter: expected %h, got %h", want.first_letter, got.first_letter);
    end
    if (got.digit_one !== want.digit_one) begin
      error_count++;
      $error("digit_one: expected %0d, got %0d", want.digit_one, got.digit_one);
    end
    if (got.digit_two !== want.digit_two) begin
      error_count++;
      $error("digit_two: expected %0d, got %0d", want.digit_two, got.digit_two);
    end
    if (got.digit_three !== want.digit_three) begin
      error_count++;
      $error("digit_three: expected %0d, got %0d", want.digit_three, got.digit_three);
    end
    if (data[23:17] !== 7'd0) begin
      error_count++;
      $error("pad: expected 0, got %h", data[23:17]);
    end
  endfunction

  function int pending_count();
    return pending_codes.size();
  endfunction
endclass

module soundex_word_encoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxWait    = 18;
  localparam int StallLimit = 1000;
  localparam int RandomItems = 450;

  logic                          clk_i  = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [sdx_pkg::InDataW-1:0]   s_axis_tdata  = '0;
  logic                          s_axis_tlast  = 1'b0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [sdx_pkg::OutDataW-1:0]  m_axis_tdata;

  soundex_code_checker code_check;
  bit                  no_idle = 1'b0;
  int                  chars_sent = 0;
  int                  words_sent = 0;
  int                  idle_cycles = 0;

  soundex_word_encoder_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // Called at a rising edge; returns at the edge where the item is taken.
  // Valid stays high so a back-to-back item needs only one assignment.
  task automatic send_char(logic [7:0] ch, logic last);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    chars_sent++;
    if (last) begin
      words_sent++;
    end
  endtask

  task automatic send_word(string w);
    for (int i = 0; i < w.len(); i++) begin
      send_char(w[i], i == w.len() - 1);
    end
  endtask

  // Stop sending until every pending code has come back.
  task automatic drain_codes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (code_check.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_word();
    string      vowels = "aeiou";
    string      hwy    = "hwy";
    string      cons   = "bcdfgjklmnpqrstvxz";
    int         len;
    int         pick;
    logic [7:0] ch;
    logic [7:0] prev;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 1;
    else if (pick == 1) len = $urandom_range(9, 14);
    else len = $urandom_range(2, 8);
    prev = "a";
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (i == 0) begin
        if (pick < 50) ch = "A" + 8'($urandom_range(0, 25));
        else if (pick < 80) ch = "a" + 8'($urandom_range(0, 25));
        else ch = 8'($urandom_range(0, 255));
      end else if (pick < 12) begin
        ch = prev;  // repeats exercise the same-class suppression
      end else if (pick < 37) begin
        ch = vowels[$urandom_range(0, vowels.len() - 1)];
      end else if (pick < 45) begin
        ch = hwy[$urandom_range(0, hwy.len() - 1)];
      end else if (pick < 82) begin
        ch = cons[$urandom_range(0, cons.len() - 1)];
      end else if (pick < 90) begin
        ch = "A" + 8'($urandom_range(0, 25));
      end else begin
        ch = 8'($urandom_range(0, 255));
      end
      send_char(ch, i == len - 1);
      prev = ch;
    end
  endtask

  // Output side: random stall before each code.
  initial begin
    int stall;
    wait (rst_ni);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Handshake monitor and stall watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        code_check.take_character(s_axis_tdata, s_axis_tlast);
        idle_cycles = 0;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        code_check.check_code(m_axis_tdata);
        idle_cycles = 0;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no item moved in %0d cycles", StallLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    code_check = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words: lead letter shares the next class, h between equals,
    // one-character word, byte extremes, vowel-separated repeat, full code
    send_word("Pfister");
    send_word("Ashcraft");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char("b", 1'b0);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    send_char("Y", 1'b0);
    send_char("w", 1'b0);
    send_char("d", 1'b0);
    send_char("l", 1'b0);
    send_char(8'hFF, 1'b1);
    drain_codes();

    while (chars_sent < 25 + RandomItems) begin
      if ($urandom_range(0, 9) == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      send_random_word();
      if (chars_sent > 25 + RandomItems / 2 && chars_sent < 25 + RandomItems / 2 + 12) begin
        drain_codes();
      end
    end
    no_idle = 1'b0;

    drain_codes();
    repeat (8) @(posedge clk_i);

    $display("Encoded %0d words from %0d characters; %0d codes compared",
             words_sent, chars_sent, code_check.codes_checked);
    $display("Mixed case, vowels, h/w/y, repeats and raw bytes under random stalls");
    if (code_check.error_count == 0 && code_check.pending_count() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
